### hdl/cdsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsm_pkg
// Shared types and constants for the concentric disk sample mapper.
// ----------------------------------------------------------------------------
package cdsm_pkg;

  localparam int ANG_W        = 32;
  localparam int QUO_W        = 30;
  localparam int CORDIC_ITERS = 30;
  localparam int GUARD_BITS   = 16;

  localparam logic [ANG_W-1:0] EIGHTH_TURN = 32'h2000_0000;
  localparam logic [31:0]      CORDIC_GAIN = 32'd2608131496;

  typedef enum logic [1:0] {
    WEDGE_EAST  = 2'd0,
    WEDGE_NORTH = 2'd1,
    WEDGE_WEST  = 2'd2,
    WEDGE_SOUTH = 2'd3
  } wedge_e;

  typedef struct packed {
    wedge_e wedge;
    logic   neg;     // ratio sign (num/den negative)
    logic   origin;  // a == b == 0
  } wedge_ctl_t;

  // arctan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;   1: t = 32'd316933406;   2: t = 32'd167458907;
      3: t = 32'd85004756;    4: t = 32'd42667331;    5: t = 32'd21354465;
      6: t = 32'd10679838;    7: t = 32'd5340245;     8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;     11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;      14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;      17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;       20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;        23: t = 32'd81;
      24: t = 32'd41;        25: t = 32'd20;         26: t = 32'd10;
      27: t = 32'd5;         28: t = 32'd3;          29: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

### hdl/cdsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsm_front
// Centers the samples, picks the wedge and registers radius and ratio operands.
// ----------------------------------------------------------------------------
module cdsm_front import cdsm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [FRAC_BITS-1:0] u_i,
  input  logic [FRAC_BITS-1:0] v_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   r_o,
  output logic [FRAC_BITS:0]   n_o,
  output logic [FRAC_BITS:0]   d_o,
  output wedge_ctl_t           ctl_o
);

  localparam int CW = FRAC_BITS + 2;
  localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  logic signed [CW-1:0] a, b, na, nb, num, den, rr;
  logic                 valid_q;
  logic [FRAC_BITS:0]   r_q, n_q, d_q, n_d, d_d;
  wedge_ctl_t           ctl_q, ctl_d;

  always_comb begin
    a  = $signed({1'b0, u_i, 1'b0}) - ONE;
    b  = $signed({1'b0, v_i, 1'b0}) - ONE;
    na = -a;
    nb = -b;
    ctl_d.origin = 1'b0;
    if (a > nb) begin
      if (a > b) begin
        ctl_d.wedge = WEDGE_EAST;  rr = a;  num = b; den = a;
      end else begin
        ctl_d.wedge = WEDGE_NORTH; rr = b;  num = a; den = b;
      end
    end else begin
      if (a < b) begin
        ctl_d.wedge = WEDGE_WEST;  rr = na; num = b; den = a;
      end else begin
        ctl_d.wedge = WEDGE_SOUTH; rr = nb; num = a; den = b;
        ctl_d.origin = (b == '0);
      end
    end
    ctl_d.neg = num[CW-1] ^ den[CW-1];
    n_d = num[CW-1] ? (FRAC_BITS+1)'(-num) : (FRAC_BITS+1)'(num);
    d_d = den[CW-1] ? (FRAC_BITS+1)'(-den) : (FRAC_BITS+1)'(den);
    if (ctl_d.origin) begin
      d_d = (FRAC_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= (FRAC_BITS+1)'(rr);
      n_q   <= n_d;
      d_q   <= d_d;
      ctl_q <= ctl_d;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = r_q;
  assign n_o     = n_q;
  assign d_o     = d_q;
  assign ctl_o   = ctl_q;

endmodule

### hdl/cdsm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsm_div
// Restoring divider, one quotient bit per stage:
// q = floor((n * 2^30 + d) / (2 * d)).
// ----------------------------------------------------------------------------
module cdsm_div import cdsm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [FRAC_BITS:0]   r_i,
  input  logic [FRAC_BITS:0]   n_i,
  input  logic [FRAC_BITS:0]   d_i,
  input  wedge_ctl_t           ctl_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   r_o,
  output logic [QUO_W-1:0]     q_o,
  output wedge_ctl_t           ctl_o
);

  localparam int RW = FRAC_BITS + 2;

  logic [RW-1:0]        rem0, den0;
  logic [QUO_W-1:0]     lo0;

  logic                 valid_q [QUO_W];
  logic [RW-1:0]        rem_q   [QUO_W];
  logic [RW-1:0]        den_q   [QUO_W];
  logic [QUO_W-1:0]     lo_q    [QUO_W];
  logic [QUO_W-1:0]     quo_q   [QUO_W];
  logic [FRAC_BITS:0]   r_q     [QUO_W];
  wedge_ctl_t           ctl_q   [QUO_W];

  // numerator high part is n + (d >> 30), low 30 bits are d
  assign rem0 = RW'(n_i) + RW'(d_i >> QUO_W);
  assign den0 = {d_i, 1'b0};
  assign lo0  = QUO_W'(d_i);

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [RW-1:0]    rem_in, den_in, rem_d;
    logic [QUO_W-1:0] lo_in, quo_in;
    logic [RW:0]      shifted;
    logic             ge;
    logic             vin;
    logic [FRAC_BITS:0] rin;
    wedge_ctl_t       cin;

    if (s == 0) begin : g_first
      assign vin = valid_i; assign rem_in = rem0; assign den_in = den0;
      assign lo_in = lo0;   assign quo_in = '0;   assign rin = r_i;
      assign cin = ctl_i;
    end else begin : g_next
      assign vin = valid_q[s-1]; assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1]; assign lo_in = lo_q[s-1];
      assign quo_in = quo_q[s-1]; assign rin = r_q[s-1];
      assign cin = ctl_q[s-1];
    end

    always_comb begin
      shifted = {rem_in, lo_in[QUO_W-1-s]};
      ge      = shifted >= {1'b0, den_in};
      rem_d   = ge ? RW'(shifted - {1'b0, den_in}) : RW'(shifted);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        lo_q[s]  <= lo_in;
        quo_q[s] <= {quo_in[QUO_W-2:0], ge};
        r_q[s]   <= rin;
        ctl_q[s] <= cin;
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign r_o     = r_q[QUO_W-1];
  assign q_o     = quo_q[QUO_W-1];
  assign ctl_o   = ctl_q[QUO_W-1];

endmodule

### hdl/cdsm_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsm_cordic
// Builds the angle, scales the radius by the CORDIC gain, and runs a
// rotation CORDIC with one micro-rotation per stage. Ends in rounding and clamping.
// ----------------------------------------------------------------------------
module cdsm_cordic import cdsm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [FRAC_BITS:0]          r_i,
  input  logic [QUO_W-1:0]            q_i,
  input  wedge_ctl_t                  ctl_i,
  output logic                        valid_o,
  output logic signed [FRAC_BITS+1:0] x_o,
  output logic signed [FRAC_BITS+1:0] y_o
);

  localparam int XW = FRAC_BITS + 19;
  localparam int ZW = ANG_W + 1;
  localparam int OW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 33;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // stage A: angle and scaled radius
  logic [ANG_W-1:0] smag, ang_d, ang_q;
  logic [PW-1:0]    prod_d;
  logic [PW-GUARD_BITS-1:0] mag_q;
  logic             va_q, vb_q;

  always_comb begin
    smag = ctl_i.neg ? (ANG_W'(0) - ANG_W'(q_i)) : ANG_W'(q_i);
    case (ctl_i.wedge)
      WEDGE_EAST:  ang_d = smag;
      WEDGE_NORTH: ang_d = (EIGHTH_TURN << 1) - smag;
      WEDGE_WEST:  ang_d = (EIGHTH_TURN << 2) + smag;
      WEDGE_SOUTH: ang_d = ctl_i.origin ? '0 :
                           (EIGHTH_TURN << 2) + (EIGHTH_TURN << 1) - smag;
      default:     ang_d = '0;
    endcase
    prod_d = PW'(r_i) * PW'(CORDIC_GAIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
      mag_q <= prod_d[PW-1:GUARD_BITS];
    end
  end

  // stage B: exact quarter turn
  logic signed [XW-1:0] x0, x_b_d, y_b_d, x_b_q, y_b_q;
  logic signed [ZW-1:0] z_b_q;

  always_comb begin
    x0 = $signed(XW'(mag_q));
    case (ang_q[ANG_W-1 -: 2])
      QUAD_0:  begin x_b_d = x0;  y_b_d = '0;  end
      QUAD_1:  begin x_b_d = '0;  y_b_d = x0;  end
      QUAD_2:  begin x_b_d = -x0; y_b_d = '0;  end
      default: begin x_b_d = '0;  y_b_d = -x0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_b_q <= x_b_d;
      y_b_q <= y_b_d;
      z_b_q <= $signed(ZW'(ang_q[ANG_W-3:0]));
    end
  end

  // micro-rotations
  logic                 vi_q [CORDIC_ITERS];
  logic signed [XW-1:0] xi_q [CORDIC_ITERS];
  logic signed [XW-1:0] yi_q [CORDIC_ITERS];
  logic signed [ZW-1:0] zi_q [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic                 vin;
    logic signed [XW-1:0] xin, yin, xs, ys;
    logic signed [ZW-1:0] zin, at;

    if (i == 0) begin : g_first
      assign vin = vb_q; assign xin = x_b_q; assign yin = y_b_q; assign zin = z_b_q;
    end else begin : g_next
      assign vin = vi_q[i-1]; assign xin = xi_q[i-1];
      assign yin = yi_q[i-1]; assign zin = zi_q[i-1];
    end

    assign xs = xin >>> i;
    assign ys = yin >>> i;
    assign at = $signed({1'b0, atan_turn(i)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vi_q[i] <= 1'b0;
      end else if (en_i) begin
        vi_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zin[ZW-1]) begin
          xi_q[i] <= xin - ys;
          yi_q[i] <= yin + xs;
          zi_q[i] <= zin - at;
        end else begin
          xi_q[i] <= xin + ys;
          yi_q[i] <= yin - xs;
          zi_q[i] <= zin + at;
        end
      end
    end
  end

  // round half up, drop guard bits, clamp to +/-1.0
  function automatic logic signed [OW-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    logic signed [XW-GUARD_BITS-1:0] t;
    logic signed [XW-GUARD_BITS-1:0] lim;
    logic signed [OW-1:0] res;
    s   = v + $signed(XW'(1) << (GUARD_BITS - 1));
    t   = s[XW-1:GUARD_BITS];
    lim = (XW-GUARD_BITS)'(1) << FRAC_BITS;
    if (t > lim) begin
      res = OW'(lim);
    end else if (t < -lim) begin
      res = OW'(-lim);
    end else begin
      res = OW'(t);
    end
    return res;
  endfunction

  assign valid_o = vi_q[CORDIC_ITERS-1];
  assign x_o     = finish(xi_q[CORDIC_ITERS-1]);
  assign y_o     = finish(yi_q[CORDIC_ITERS-1]);

endmodule

### hdl/concentric_disk_sample_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// concentric_disk_sample_map
// Concentric square-to-disk mapping of sample pairs, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: sample_u_i / sample_v_i with in_valid_i, in_stall_o.
// Output channel: disk_x_o / disk_y_o with out_valid_o, out_stall_i.
// A beat moves when valid is high and stall is low.
// Throughput: one beat per cycle while the output is not stalled. A beat runs from input to
// output valid through 1 wedge stage, 30 divider stages (one
// quotient bit each), 2 angle/gain stages, 30 CORDIC micro-rotation stages
// and the output register.
// The whole pipeline advances together; it holds while the output register
// carries a beat and the receiver stalls, and in_stall_o is raised then.
// Results leave in input order.
// Reset clears all valid bits; the pipeline is empty and accepts at once.
// ----------------------------------------------------------------------------
module concentric_disk_sample_map import cdsm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [FRAC_BITS-1:0]        sample_u_i,
  input  logic [FRAC_BITS-1:0]        sample_v_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [FRAC_BITS+1:0] disk_x_o,
  output logic signed [FRAC_BITS+1:0] disk_y_o
);

  logic                        en;
  logic                        f_valid, d_valid, c_valid;
  logic [FRAC_BITS:0]          f_r, f_n, f_d, d_r;
  logic [QUO_W-1:0]            d_q;
  wedge_ctl_t                  f_ctl, d_ctl;
  logic signed [FRAC_BITS+1:0] c_x, c_y;
  logic                        out_valid_q;
  logic signed [FRAC_BITS+1:0] x_q, y_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  cdsm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .u_i(sample_u_i), .v_i(sample_v_i),
    .valid_o(f_valid), .r_o(f_r), .n_o(f_n), .d_o(f_d), .ctl_o(f_ctl)
  );

  cdsm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid),
    .r_i(f_r), .n_i(f_n), .d_i(f_d), .ctl_i(f_ctl),
    .valid_o(d_valid), .r_o(d_r), .q_o(d_q), .ctl_o(d_ctl)
  );

  cdsm_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid),
    .r_i(d_r), .q_i(d_q), .ctl_i(d_ctl),
    .valid_o(c_valid), .x_o(c_x), .y_o(c_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= c_x;
      y_q <= c_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign disk_x_o    = x_q;
  assign disk_y_o    = y_q;

  localparam logic signed [FRAC_BITS+1:0] LIM = (FRAC_BITS+2)'(1) << FRAC_BITS;

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (x_q <= LIM && x_q >= -LIM))
    else $error("disk_x out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (y_q <= LIM && y_q >= -LIM))
    else $error("disk_y out of range");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(x_q) && $stable(y_q)))
    else $error("held beat changed");

endmodule
